// File: rtl/hcb_pkg.sv
`timescale 1ns / 1ps

package hcb_pkg;

  localparam int unsigned SymbolCountDef = 256;
  localparam int unsigned CountBitsDef   = 16;
  localparam int unsigned MaxCodeLenDef  = 32;

  localparam logic [7:0] INNER_KEY = 8'd42;

  localparam logic [1:0] KIND_COUNT  = 2'd0;
  localparam logic [1:0] KIND_BUILD  = 2'd1;
  localparam logic [1:0] KIND_ENCODE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic        present;
    logic [1:0]  status;
  } out_item_t;

endpackage

// File: rtl/hcb_ram.sv
`timescale 1ns / 1ps

module hcb_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: rtl/hcb_hist.sv
`timescale 1ns / 1ps

module hcb_hist #(
  parameter int unsigned SYMBOL_COUNT = hcb_pkg::SymbolCountDef,
  parameter int unsigned COUNT_BITS   = hcb_pkg::CountBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clr_i,
  input  logic                            rd_en_i,
  input  logic [$clog2(SYMBOL_COUNT)-1:0] rd_addr_i,
  output logic [COUNT_BITS-1:0]           rd_data_o,
  input  logic                            wr_en_i,
  input  logic [$clog2(SYMBOL_COUNT)-1:0] wr_addr_i,
  input  logic [COUNT_BITS-1:0]           wr_data_i
);

  logic [COUNT_BITS-1:0]   mem_q [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_q;
  logic [COUNT_BITS-1:0]   rd_q;
  logic                    rd_vld_q;

  // counts live in the array, a cleared entry reads as zero
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: rtl/huffman_code_builder_encoder_top.sv
`timescale 1ns / 1ps
// count items go through S_CNT, clear items end in S_IDLE, encode items through S_ENC
// to the output register; build makes leaves in symbol order, then per merge two scans of
// the node memory (one node read a cycle, up to 2*SYMBOL_COUNT reads each),
// then S_CRD, S_CW0, S_CW1 per inner node and S_TRD, S_TWR per leaf for code assignment
// the single-port-read node memory scan sets the build time
// async active-low reset clears histogram, total, flags; node/code memories need no clear

module huffman_code_builder_encoder_top #(
  parameter int unsigned SYMBOL_COUNT = hcb_pkg::SymbolCountDef,
  parameter int unsigned COUNT_BITS   = hcb_pkg::CountBitsDef,
  parameter int unsigned MAX_CODE_LEN = hcb_pkg::MaxCodeLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hcb_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hcb_pkg::out_item_t out_data_o
);

  localparam int unsigned SYM_W   = $clog2(SYMBOL_COUNT);
  localparam int unsigned NODES   = 2 * SYMBOL_COUNT;
  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned CODE_W  = MAX_CODE_LEN;
  localparam int unsigned LEN_W   = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned CWORD_W = CODE_W + LEN_W;
  localparam int unsigned TAB_W   = 38;

  // node word layout: live, key, weight, zero child, one child
  localparam int unsigned N_ONE   = 0;
  localparam int unsigned N_ZERO  = NODE_W;
  localparam int unsigned N_W     = 2 * NODE_W;
  localparam int unsigned N_KEY   = N_W + COUNT_BITS;
  localparam int unsigned N_LIVE  = N_KEY + 8;
  localparam int unsigned NODE_DW = N_LIVE + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CNT   = 4'd1;
  localparam logic [3:0] S_ENC   = 4'd2;
  localparam logic [3:0] S_LRD   = 4'd3;
  localparam logic [3:0] S_LWR   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_TAKE  = 4'd6;
  localparam logic [3:0] S_MERGE = 4'd7;
  localparam logic [3:0] S_ROOT  = 4'd8;
  localparam logic [3:0] S_CRD   = 4'd9;
  localparam logic [3:0] S_CW0   = 4'd10;
  localparam logic [3:0] S_CW1   = 4'd11;
  localparam logic [3:0] S_TRD   = 4'd12;
  localparam logic [3:0] S_TWR   = 4'd13;
  localparam logic [3:0] S_BOUT  = 4'd14;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [3:0]            state_q;
  logic [COUNT_BITS-1:0] total_q;
  logic                  ovf_q;
  logic                  built_q;
  logic [7:0]            sym_q;
  logic [NODE_W-1:0]     used_q;
  logic [SYM_W:0]        leaves_q;
  logic [SYM_W:0]        live_q;
  logic [SYM_W:0]        s_q;
  logic [NODE_W-1:0]     idx_q;
  logic                  pend_q;
  logic [NODE_W-1:0]     pidx_q;
  logic                  found_q;
  logic [NODE_DW-1:0]    best_q;
  logic [NODE_W-1:0]     best_idx_q;
  logic                  second_q;
  logic [NODE_W-1:0]     first_idx_q;
  logic [COUNT_BITS-1:0] first_w_q;
  logic [NODE_W-1:0]     second_idx_q;
  logic [COUNT_BITS-1:0] second_w_q;
  logic [NODE_W-1:0]     p_q;
  logic [NODE_W-1:0]     one_idx_q;
  logic [CWORD_W-1:0]    one_code_q;
  logic                  out_valid_q;
  hcb_pkg::out_item_t    out_q;

  // memory ports
  logic                  h_rd, h_wr, h_clr;
  logic [SYM_W-1:0]      h_rd_addr, h_wr_addr;
  logic [COUNT_BITS-1:0] h_rd_data, h_wr_data;
  logic                  n_rd, n_wr;
  logic [NODE_W-1:0]     n_rd_addr, n_wr_addr;
  logic [NODE_DW-1:0]    n_rd_data, n_wr_data;
  logic                  c_rd, c_wr;
  logic [NODE_W-1:0]     c_rd_addr, c_wr_addr;
  logic [CWORD_W-1:0]    c_rd_data, c_wr_data;
  logic                  t_rd, t_wr;
  logic [SYM_W-1:0]      t_rd_addr, t_wr_addr;
  logic [TAB_W-1:0]      t_rd_data, t_wr_data;

  logic                  in_acc;
  logic                  out_free;
  logic                  in_range;
  logic                  sym_q_in_range;
  logic                  cnt_ovf;
  logic [1:0]            built_status;
  logic                  better;
  logic [CODE_W-1:0]     par_code;
  logic [LEN_W-1:0]      par_len;
  logic [CWORD_W-1:0]    ext0, ext1;
  logic [CODE_W+31:0]    code_wide;
  logic [LEN_W+5:0]      len_wide;
  hcb_pkg::out_item_t    res;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_range       = ({1'b0, in_data_i.symbol} < 9'(SYMBOL_COUNT));
  assign sym_q_in_range = ({1'b0, sym_q} < 9'(SYMBOL_COUNT));
  assign cnt_ovf        = (h_rd_data == COUNT_MAX) || (total_q == COUNT_MAX);
  assign built_status   = ovf_q ? hcb_pkg::ST_OVERFLOW :
                          (total_q == '0) ? hcb_pkg::ST_EMPTY : hcb_pkg::ST_OK;

  // (weight, key) strictly smaller; equal keys keep the older node found first
  assign better = n_rd_data[N_LIVE] &&
                  (!found_q ||
                   (n_rd_data[N_W +: COUNT_BITS] < best_q[N_W +: COUNT_BITS]) ||
                   ((n_rd_data[N_W +: COUNT_BITS] == best_q[N_W +: COUNT_BITS]) &&
                    (n_rd_data[N_KEY +: 8] < best_q[N_KEY +: 8])));

  // child code: append one bit unless the parent is already at max length
  assign par_code = c_rd_data[CODE_W-1:0];
  assign par_len  = c_rd_data[CWORD_W-1:CODE_W];
  always_comb begin
    if (par_len >= LEN_W'(MAX_CODE_LEN)) begin
      ext0 = c_rd_data;
      ext1 = c_rd_data;
    end else begin
      ext0 = {par_len + LEN_W'(1), par_code[CODE_W-2:0], 1'b0};
      ext1 = {par_len + LEN_W'(1), par_code[CODE_W-2:0], 1'b1};
    end
  end

  // code table entry: low 32 code bits and 6-bit length
  assign code_wide = {32'b0, par_code};
  assign len_wide  = {6'b0, par_len};

  always_comb begin
    h_rd = 1'b0; h_wr = 1'b0; h_clr = 1'b0;
    h_rd_addr = in_data_i.symbol[SYM_W-1:0];
    h_wr_addr = sym_q[SYM_W-1:0];
    h_wr_data = h_rd_data + COUNT_BITS'(1);
    n_rd = 1'b0; n_wr = 1'b0;
    n_rd_addr = idx_q;
    n_wr_addr = used_q;
    n_wr_data = '0;
    c_rd = 1'b0; c_wr = 1'b0;
    c_rd_addr = p_q;
    c_wr_addr = p_q;
    c_wr_data = '0;
    t_rd = 1'b0; t_wr = 1'b0;
    t_rd_addr = in_data_i.symbol[SYM_W-1:0];
    t_wr_addr = n_rd_data[N_KEY +: SYM_W];
    t_wr_data = {code_wide[31:0], len_wide[5:0]};
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.kind)
            hcb_pkg::KIND_COUNT:  h_rd = in_range;
            hcb_pkg::KIND_ENCODE: begin
              h_rd = 1'b1;
              t_rd = 1'b1;
            end
            hcb_pkg::KIND_CLEAR:  h_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_CNT: h_wr = !cnt_ovf;
      S_LRD: begin
        h_rd      = (s_q != (SYM_W+1)'(SYMBOL_COUNT));
        h_rd_addr = s_q[SYM_W-1:0];
      end
      S_LWR: begin
        n_wr      = (h_rd_data != '0);
        n_wr_data = {1'b1, 8'(s_q[SYM_W-1:0]), h_rd_data, {NODE_W{1'b0}}, {NODE_W{1'b0}}};
      end
      S_SCAN: n_rd = (idx_q < used_q);
      S_TAKE: begin
        n_wr      = 1'b1;
        n_wr_addr = best_idx_q;
        n_wr_data = {1'b0, best_q[NODE_DW-2:0]};
      end
      S_MERGE: begin
        n_wr      = 1'b1;
        n_wr_data = {1'b1, hcb_pkg::INNER_KEY, first_w_q + second_w_q,
                     second_idx_q, first_idx_q};
      end
      S_ROOT: begin
        c_wr      = 1'b1;
        c_wr_addr = used_q - NODE_W'(1);
      end
      S_CRD: begin
        n_rd      = (p_q >= leaves_q);
        c_rd      = (p_q >= leaves_q);
        n_rd_addr = p_q;
      end
      S_CW0: begin
        c_wr      = 1'b1;
        c_wr_addr = n_rd_data[N_ZERO +: NODE_W];
        c_wr_data = ext0;
      end
      S_CW1: begin
        c_wr      = 1'b1;
        c_wr_addr = one_idx_q;
        c_wr_data = one_code_q;
      end
      S_TRD: begin
        n_rd      = (s_q != leaves_q);
        c_rd      = (s_q != leaves_q);
        n_rd_addr = s_q;
        c_rd_addr = s_q;
      end
      S_TWR: t_wr = 1'b1;
      default: ;
    endcase
  end

  // result of an encode item
  always_comb begin
    res = '0;
    res.present = sym_q_in_range && (h_rd_data != '0);
    if (!built_q) begin
      res.status = hcb_pkg::ST_NOT_BUILT;
    end else begin
      res.status = built_status;
      if (res.present) begin
        res.code_bits   = t_rd_data[TAB_W-1:6];
        res.code_length = t_rd_data[5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            sym_q <= in_data_i.symbol;
            case (in_data_i.kind)
              hcb_pkg::KIND_COUNT: begin
                built_q <= 1'b0;
                if (in_range) begin
                  state_q <= S_CNT;
                end
              end
              hcb_pkg::KIND_BUILD: begin
                used_q  <= '0;
                s_q     <= '0;
                state_q <= S_LRD;
              end
              hcb_pkg::KIND_ENCODE: state_q <= S_ENC;
              hcb_pkg::KIND_CLEAR: begin
                total_q <= '0;
                ovf_q   <= 1'b0;
                built_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_CNT: begin
          if (cnt_ovf) begin
            ovf_q <= 1'b1;
          end else begin
            total_q <= total_q + COUNT_BITS'(1);
          end
          state_q <= S_IDLE;
        end
        S_ENC: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= res;
            state_q     <= S_IDLE;
          end
        end
        // one leaf per present symbol, in symbol order
        S_LRD: begin
          if (s_q == (SYM_W+1)'(SYMBOL_COUNT)) begin
            built_q  <= 1'b1;
            leaves_q <= (SYM_W+1)'(used_q);
            live_q   <= (SYM_W+1)'(used_q);
            idx_q    <= '0;
            pend_q   <= 1'b0;
            found_q  <= 1'b0;
            second_q <= 1'b0;
            if (used_q == '0) begin
              state_q <= S_BOUT;
            end else if (used_q == NODE_W'(1)) begin
              state_q <= S_ROOT;
            end else begin
              state_q <= S_SCAN;
            end
          end else begin
            state_q <= S_LWR;
          end
        end
        S_LWR: begin
          if (h_rd_data != '0) begin
            used_q <= used_q + NODE_W'(1);
          end
          s_q     <= s_q + (SYM_W+1)'(1);
          state_q <= S_LRD;
        end
        // pipelined scan: issue read of idx, judge the node read last cycle
        S_SCAN: begin
          if (idx_q < used_q) begin
            idx_q  <= idx_q + NODE_W'(1);
            pidx_q <= idx_q;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q && better) begin
            best_q     <= n_rd_data;
            best_idx_q <= pidx_q;
            found_q    <= 1'b1;
          end
          if (!(idx_q < used_q) && !pend_q) begin
            state_q <= S_TAKE;
          end
        end
        S_TAKE: begin
          idx_q   <= '0;
          found_q <= 1'b0;
          if (!second_q) begin
            first_idx_q <= best_idx_q;
            first_w_q   <= best_q[N_W +: COUNT_BITS];
            second_q    <= 1'b1;
            state_q     <= S_SCAN;
          end else begin
            second_idx_q <= best_idx_q;
            second_w_q   <= best_q[N_W +: COUNT_BITS];
            state_q      <= S_MERGE;
          end
        end
        S_MERGE: begin
          used_q   <= used_q + NODE_W'(1);
          live_q   <= live_q - (SYM_W+1)'(1);
          second_q <= 1'b0;
          if (live_q > (SYM_W+1)'(2)) begin
            state_q <= S_SCAN;
          end else begin
            state_q <= S_ROOT;
          end
        end
        // walk inner nodes from the root down, pushing codes to children
        S_ROOT: begin
          p_q     <= used_q - NODE_W'(1);
          state_q <= S_CRD;
        end
        S_CRD: begin
          if (p_q >= leaves_q) begin
            state_q <= S_CW0;
          end else begin
            s_q     <= '0;
            state_q <= S_TRD;
          end
        end
        S_CW0: begin
          one_idx_q  <= n_rd_data[N_ONE +: NODE_W];
          one_code_q <= ext1;
          state_q    <= S_CW1;
        end
        S_CW1: begin
          p_q     <= p_q - NODE_W'(1);
          state_q <= S_CRD;
        end
        // copy leaf codes into the per-symbol table
        S_TRD: begin
          if (s_q == leaves_q) begin
            state_q <= S_BOUT;
          end else begin
            state_q <= S_TWR;
          end
        end
        S_TWR: begin
          s_q     <= s_q + (SYM_W+1)'(1);
          state_q <= S_TRD;
        end
        S_BOUT: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_q.code_bits   <= '0;
            out_q.code_length <= '0;
            out_q.present     <= (total_q != '0);
            out_q.status      <= built_status;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  hcb_hist #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .COUNT_BITS  (COUNT_BITS)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (h_clr),
    .rd_en_i  (h_rd),
    .rd_addr_i(h_rd_addr),
    .rd_data_o(h_rd_data),
    .wr_en_i  (h_wr),
    .wr_addr_i(h_wr_addr),
    .wr_data_i(h_wr_data)
  );

  hcb_ram #(.DEPTH(NODES), .WIDTH(NODE_DW)) u_node_ram (
    .clk_i    (clk_i),
    .rd_en_i  (n_rd),
    .rd_addr_i(n_rd_addr),
    .rd_data_o(n_rd_data),
    .wr_en_i  (n_wr),
    .wr_addr_i(n_wr_addr),
    .wr_data_i(n_wr_data)
  );

  hcb_ram #(.DEPTH(NODES), .WIDTH(CWORD_W)) u_code_ram (
    .clk_i    (clk_i),
    .rd_en_i  (c_rd),
    .rd_addr_i(c_rd_addr),
    .rd_data_o(c_rd_data),
    .wr_en_i  (c_wr),
    .wr_addr_i(c_wr_addr),
    .wr_data_i(c_wr_data)
  );

  hcb_ram #(.DEPTH(SYMBOL_COUNT), .WIDTH(TAB_W)) u_table_ram (
    .clk_i    (clk_i),
    .rd_en_i  (t_rd),
    .rd_addr_i(t_rd_addr),
    .rd_data_o(t_rd_data),
    .wr_en_i  (t_wr),
    .wr_addr_i(t_wr_addr),
    .wr_data_i(t_wr_data)
  );

`ifndef SYNTHESIS
  // a take always follows a scan that found a live node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TAKE |-> found_q) else $error("take without live node");

  // the two merged nodes differ
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MERGE |-> first_idx_q != second_idx_q) else $error("merge of one node");

  // scanning only while at least two nodes remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> (live_q >= (SYM_W+1)'(2)) && (live_q <= leaves_q))
    else $error("live node count out of range");

  // a build result is only sent once codes are marked built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BOUT |-> built_q) else $error("build result before built");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // one pending item for the driver, with an optional hold until all results are back
  typedef struct {
    hcb_pkg::in_item_t item;
    bit                hold;
  } pending_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  hcb_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  hcb_pkg::out_item_t out_data;

  pending_t           pending_items[$];
  hcb_pkg::out_item_t expected_codes[$];
  int                 errors = 0;
  int                 sent = 0;
  int                 idle_cycles = 0;
  bit                 taken = 1'b0;

  // running histogram and built code table, as the block should hold them
  int unsigned sym_count[256];
  int unsigned msg_total;
  bit          count_ovf;
  bit          codes_built;
  logic [31:0] tbl_bits[256];
  int unsigned tbl_len[256];

  huffman_code_builder_encoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #1 clk_i = ~clk_i;

  // pick the lowest live node by (weight, key); lower index wins a tie
  function automatic int pick_lowest(ref bit live[512], ref int unsigned wgt[512],
                                     ref int unsigned key[512], input int used);
    int best;
    best = -1;
    for (int i = 0; i < used; i++) begin
      if (!live[i]) continue;
      if (best < 0 || wgt[i] < wgt[best] || (wgt[i] == wgt[best] && key[i] < key[best]))
        best = i;
    end
    live[best] = 1'b0;
    return best;
  endfunction

  task automatic build_code_table();
    int unsigned wgt[512];
    int unsigned key[512];
    int          zero_kid[512];
    int          one_kid[512];
    bit          live[512];
    logic [31:0] path[512];
    int unsigned depth[512];
    int          used;
    int          leaves;
    int          a;
    int          b;
    int          p;
    used = 0;
    for (int s = 0; s < 256; s++) begin
      tbl_bits[s] = '0;
      tbl_len[s]  = 0;
    end
    for (int i = 0; i < 512; i++) live[i] = 1'b0;
    for (int s = 0; s < 256; s++) begin
      if (sym_count[s] == 0) continue;
      wgt[used]  = sym_count[s];
      key[used]  = s;
      live[used] = 1'b1;
      used++;
    end
    codes_built = 1'b1;
    if (used == 0) return;
    leaves = used;
    for (int n = leaves; n > 1; n--) begin
      a = pick_lowest(live, wgt, key, used);
      b = pick_lowest(live, wgt, key, used);
      wgt[used]      = wgt[a] + wgt[b];
      key[used]      = hcb_pkg::INNER_KEY;
      zero_kid[used] = b;
      one_kid[used]  = a;
      live[used]     = 1'b1;
      used++;
    end
    path[used-1]  = '0;
    depth[used-1] = 0;
    for (int i = used; i > leaves; i--) begin
      p = i - 1;
      // paths saturate at the maximum code length
      for (int c = 0; c < 2; c++) begin
        a = (c == 0) ? zero_kid[p] : one_kid[p];
        if (depth[p] >= hcb_pkg::MaxCodeLenDef) begin
          path[a]  = path[p];
          depth[a] = depth[p];
        end else begin
          path[a]  = {path[p][30:0], c[0]};
          depth[a] = depth[p] + 1;
        end
      end
    end
    for (int i = 0; i < leaves; i++) begin
      tbl_bits[key[i]] = path[i];
      tbl_len[key[i]]  = depth[i];
    end
  endtask

  function automatic logic [1:0] table_status();
    if (count_ovf) return hcb_pkg::ST_OVERFLOW;
    if (msg_total == 0) return hcb_pkg::ST_EMPTY;
    return hcb_pkg::ST_OK;
  endfunction

  task automatic predict_item(input hcb_pkg::in_item_t it);
    hcb_pkg::out_item_t r;
    r = '0;
    case (it.kind)
      hcb_pkg::KIND_COUNT: begin
        codes_built = 1'b0;
        if (sym_count[it.symbol] >= 65535 || msg_total >= 65535) begin
          count_ovf = 1'b1;
        end else begin
          sym_count[it.symbol]++;
          msg_total++;
        end
      end
      hcb_pkg::KIND_CLEAR: begin
        for (int s = 0; s < 256; s++) sym_count[s] = 0;
        msg_total   = 0;
        count_ovf   = 1'b0;
        codes_built = 1'b0;
      end
      hcb_pkg::KIND_BUILD: begin
        build_code_table();
        r.present = (msg_total != 0);
        r.status  = table_status();
        expected_codes.insert(expected_codes.size(), r);
      end
      default: begin
        r.present = (sym_count[it.symbol] != 0);
        if (!codes_built) begin
          r.status = hcb_pkg::ST_NOT_BUILT;
        end else begin
          if (r.present) begin
            r.code_bits   = tbl_bits[it.symbol];
            r.code_length = tbl_len[it.symbol][5:0];
          end
          r.status = table_status();
        end
        expected_codes.insert(expected_codes.size(), r);
      end
    endcase
  endtask

  // accepted input items feed the predictor at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) begin
      taken <= 1'b1;
      predict_item(in_data);
      idle_cycles = 0;
    end else begin
      taken <= 1'b0;
    end
  end

  // monitor: each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      idle_cycles = 0;
      if (expected_codes.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h/%0d/%b/%0d", $time,
                 out_data.code_bits, out_data.code_length, out_data.present, out_data.status);
        errors++;
      end else begin
        hcb_pkg::out_item_t e;
        e = expected_codes.pop_front();
        if (out_data.code_bits !== e.code_bits || out_data.code_length !== e.code_length ||
            out_data.present !== e.present || out_data.status !== e.status) begin
          $display("%0t: mismatch expected %h/%0d/%b/%0d actual %h/%0d/%b/%0d", $time,
                   e.code_bits, e.code_length, e.present, e.status,
                   out_data.code_bits, out_data.code_length, out_data.present,
                   out_data.status);
          errors++;
        end
      end
    end
  end

  // watchdog: a full 256-symbol build is the longest quiet stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= 1500000) begin
        $display("huffman_code_builder_encoder_top test failed");
        $finish;
      end
    end
  end

  // driver: inputs move on the falling edge
  always @(negedge clk_i) begin
    int send_idle;
    int recv_idle;
    // idling schedule: receiver-heavy, then sender-heavy, then none
    if (sent < 400) begin
      send_idle = 23;
      recv_idle = 51;
    end else if (sent < 800) begin
      send_idle = 51;
      recv_idle = 23;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    out_stall <= ($urandom_range(99) < recv_idle);
    if (rst_ni && (!in_valid || taken)) begin
      if (pending_items.size() == 0 ||
          (pending_items[0].hold && (expected_codes.size() != 0 || out_valid))) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(99) >= send_idle) begin
        pending_t nx;
        nx = pending_items.pop_front();
        in_data  <= nx.item;
        in_valid <= 1'b1;
        sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic add_item(input logic [1:0] k, input int s, input bit hold = 1'b0);
    pending_t p;
    p.item.kind   = k;
    p.item.symbol = s[7:0];
    p.hold        = hold;
    pending_items.insert(pending_items.size(), p);
  endtask

  initial begin
    int alpha[$];
    int n;
    int quiet;
    for (int s = 0; s < 256; s++) sym_count[s] = 0;
    msg_total   = 0;
    count_ovf   = 1'b0;
    codes_built = 1'b0;

    // directed: not built, empty message, extremes, lone symbol, equal-count ties
    add_item(hcb_pkg::KIND_ENCODE, 3);
    add_item(hcb_pkg::KIND_BUILD, 255);
    add_item(hcb_pkg::KIND_ENCODE, 0);
    add_item(hcb_pkg::KIND_COUNT, 0);
    add_item(hcb_pkg::KIND_COUNT, 255);
    add_item(hcb_pkg::KIND_COUNT, 255);
    add_item(hcb_pkg::KIND_ENCODE, 255);
    add_item(hcb_pkg::KIND_BUILD, 0);
    add_item(hcb_pkg::KIND_ENCODE, 0);
    add_item(hcb_pkg::KIND_ENCODE, 255);
    add_item(hcb_pkg::KIND_ENCODE, 7);
    add_item(hcb_pkg::KIND_CLEAR, 255);
    add_item(hcb_pkg::KIND_COUNT, 200);
    add_item(hcb_pkg::KIND_COUNT, 200);
    add_item(hcb_pkg::KIND_BUILD, 170);
    add_item(hcb_pkg::KIND_ENCODE, 200);
    add_item(hcb_pkg::KIND_CLEAR, 0);
    add_item(hcb_pkg::KIND_COUNT, 5);
    add_item(hcb_pkg::KIND_COUNT, 6);
    add_item(hcb_pkg::KIND_COUNT, 7);
    add_item(hcb_pkg::KIND_COUNT, 42);
    add_item(hcb_pkg::KIND_BUILD, 85);
    add_item(hcb_pkg::KIND_ENCODE, 5);
    add_item(hcb_pkg::KIND_ENCODE, 6);
    add_item(hcb_pkg::KIND_ENCODE, 42);

    // random episodes: small alphabets keep each build short
    while (pending_items.size() < 830) begin
      if ($urandom_range(9) < 7) add_item(hcb_pkg::KIND_CLEAR, $urandom_range(255));
      alpha.delete();
      n = $urandom_range(2, 9);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(5))
          0: alpha.insert(alpha.size(), 0);
          1: alpha.insert(alpha.size(), 255);
          default: alpha.insert(alpha.size(), $urandom_range(255));
        endcase
      end
      n = $urandom_range(3, 30);
      for (int i = 0; i < n; i++)
        add_item(hcb_pkg::KIND_COUNT,
                 alpha[$urandom_range(alpha.size() - 1) >> $urandom_range(1)]);
      if ($urandom_range(9) == 0) add_item(hcb_pkg::KIND_ENCODE, alpha[0]);
      add_item(hcb_pkg::KIND_BUILD, $urandom_range(255));
      n = $urandom_range(2, 7);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(3) == 0) add_item(hcb_pkg::KIND_ENCODE, $urandom_range(255));
        else add_item(hcb_pkg::KIND_ENCODE, alpha[$urandom_range(alpha.size() - 1)]);
      end
      // stale table after a late count
      if ($urandom_range(7) == 0) begin
        add_item(hcb_pkg::KIND_COUNT, alpha[0]);
        add_item(hcb_pkg::KIND_ENCODE, alpha[0]);
      end
    end

    // full alphabet build, entered only once the block has gone quiet
    add_item(hcb_pkg::KIND_CLEAR, 0, 1'b1);
    for (int s = 0; s < 256; s++) begin
      add_item(hcb_pkg::KIND_COUNT, s);
      if (s % 5 == 0) add_item(hcb_pkg::KIND_COUNT, s);
    end
    add_item(hcb_pkg::KIND_BUILD, 0);
    for (int i = 0; i < 12; i++) add_item(hcb_pkg::KIND_ENCODE, $urandom_range(255));
    add_item(hcb_pkg::KIND_ENCODE, 0);
    add_item(hcb_pkg::KIND_ENCODE, 255);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_codes.size() != 0)
      @(posedge clk_i);
    quiet = 0;
    while (quiet < 20) begin
      @(posedge clk_i);
      quiet++;
    end
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("huffman_code_builder_encoder_top test passed");
    end else begin
      $display("huffman_code_builder_encoder_top test failed");
    end
    $finish;
  end

endmodule
